@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define SGN_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Block clock and reset.
`define SGN_ASSERT_CLK(label, prop, msg) \
    `SGN_ASSERT(label, aclk, aresetn, prop, msg)

`endif

@@ hw/rtl/sgn_pkg.sv @@
package sgn_pkg;

    localparam int GAIN_W    = 13;                 // gain field width
    localparam int FRAC_BITS = 16;                 // fraction bits of the quotient
    localparam int QUOT_W    = GAIN_W + FRAC_BITS; // unsigned quotient width
    localparam int MANT_W    = 27;                 // slope_mantissa width
    localparam int SHIFT_W   = 4;                  // slope_shift width

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_NORM,
        ST_OUT
    } sgn_state_t;

    typedef enum logic [1:0] {
        N_IDLE,
        N_ALIGN,
        N_FIT
    } norm_state_t;

    typedef struct packed {
        logic start;
        logic neg;
    } norm_req_t;

    typedef struct packed {
        logic                 done;
        logic [MANT_W-1:0]    mant;
        logic [SHIFT_W-1:0]   shift;
    } norm_rsp_t;

endpackage

@@ hw/rtl/sgn_div.sv @@
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient = floor(dend * 2^FRC_W / dvsr), dvsr must be nonzero.
module sgn_div #(
    parameter int DEND_W = 13,
    parameter int FRC_W  = 16,
    parameter int DV_W   = 14
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DEND_W-1:0]        dend,
    input  logic [DV_W-1:0]          dvsr,
    output logic                     done,
    output logic [DEND_W+FRC_W-1:0]  quot
);

    localparam int Q_W   = DEND_W + FRC_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [Q_W-1:0]   work_reg, work_next;
    logic [DV_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]  dvsr_reg, dvsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DV_W:0]    rem_sh;
    logic [DV_W:0]    diff;
    logic             ge;

    always_comb begin
        rem_sh = {rem_reg, work_reg[Q_W-1]};
        diff   = rem_sh - {1'b0, dvsr_reg};
        ge     = (rem_sh >= {1'b0, dvsr_reg});
    end

    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // load dividend with the fraction zeros appended
            work_next = {dend, {FRC_W{1'b0}}};
            rem_next  = '0;
            dvsr_next = dvsr;
            cnt_next  = CNT_W'(Q_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            work_next = {work_reg[Q_W-2:0], ge};
            rem_next  = ge ? diff[DV_W-1:0] : rem_sh[DV_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done = done_reg;
    assign quot = work_reg;

    `SGN_ASSERT_CLK(a_div_rem_below_dvsr, busy_reg |-> (rem_reg < dvsr_reg), "divider remainder not below divisor")

endmodule

@@ hw/rtl/sgn_norm.sv @@
`include "assert_macros.svh"

// Serial shift search: align the quotient to COEF_BITS fraction bits, then
// shift right one bit a cycle until the slope fits below 2^COEF_BITS.
module sgn_norm #(
    parameter int COEF_BITS = 13
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sgn_pkg::norm_req_t          req,
    input  logic [sgn_pkg::QUOT_W-1:0]  quot,
    output sgn_pkg::norm_rsp_t          rsp
);

    localparam int Q_W     = sgn_pkg::QUOT_W;
    localparam int MANT_W  = sgn_pkg::MANT_W;
    localparam int SHIFT_W = sgn_pkg::SHIFT_W;
    localparam int ALIGN   = sgn_pkg::FRAC_BITS - COEF_BITS;
    localparam int K_W     = $clog2(ALIGN + 2);
    localparam int S_W     = $clog2(COEF_BITS + 1);
    localparam logic [Q_W-1:0] LIM = Q_W'((64'd1 << COEF_BITS) - 64'd1);

    sgn_pkg::norm_state_t state_reg, state_next;

    logic [Q_W-1:0]     t_reg, t_next;
    logic               sticky_reg, sticky_next;
    logic               neg_reg, neg_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [S_W-1:0]     s_reg, s_next;
    logic [MANT_W-1:0]  mant_reg, mant_next;
    logic [SHIFT_W-1:0] shift_out_reg, shift_out_next;
    logic               done_reg, done_next;

    logic               over;
    logic [Q_W:0]       neg_val;

    always_comb begin
        over    = (t_reg[Q_W-1:COEF_BITS] != '0);
        neg_val = '0 - ({1'b0, t_reg} + {{Q_W{1'b0}}, sticky_reg});
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sgn_pkg::N_IDLE:  if (req.start) state_next = sgn_pkg::N_ALIGN;
            sgn_pkg::N_ALIGN: if (k_reg == '0) state_next = sgn_pkg::N_FIT;
            sgn_pkg::N_FIT: begin
                if (neg_reg || !over || s_reg == '0) state_next = sgn_pkg::N_IDLE;
            end
            default:          state_next = sgn_pkg::N_IDLE;
        endcase
    end

    always_comb begin
        t_next         = t_reg;
        sticky_next    = sticky_reg;
        neg_next       = neg_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        mant_next      = mant_reg;
        shift_out_next = shift_out_reg;
        done_next      = 1'b0;
        unique case (state_reg)
            sgn_pkg::N_IDLE: begin
                if (req.start) begin
                    t_next      = quot;
                    sticky_next = 1'b0;
                    neg_next    = req.neg;
                    k_next      = K_W'(ALIGN);
                    s_next      = S_W'(COEF_BITS);
                end
            end
            sgn_pkg::N_ALIGN: begin
                // drop the fraction bits below COEF_BITS, keep a sticky bit
                if (k_reg != '0) begin
                    t_next      = {1'b0, t_reg[Q_W-1:1]};
                    sticky_next = sticky_reg | t_reg[0];
                    k_next      = k_reg - K_W'(1);
                end
            end
            sgn_pkg::N_FIT: begin
                if (neg_reg) begin
                    // floor of a negative value: negate the rounded-up magnitude
                    mant_next      = neg_val[MANT_W-1:0];
                    shift_out_next = SHIFT_W'(s_reg);
                    done_next      = 1'b1;
                end else if (!over) begin
                    mant_next      = t_reg[MANT_W-1:0];
                    shift_out_next = SHIFT_W'(s_reg);
                    done_next      = 1'b1;
                end else if (s_reg == '0) begin
                    // nothing fits: saturate
                    mant_next      = LIM[MANT_W-1:0];
                    shift_out_next = '0;
                    done_next      = 1'b1;
                end else begin
                    t_next = {1'b0, t_reg[Q_W-1:1]};
                    s_next = s_reg - S_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sgn_pkg::N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg         <= t_next;
        sticky_reg    <= sticky_next;
        neg_reg       <= neg_next;
        k_reg         <= k_next;
        s_reg         <= s_next;
        mant_reg      <= mant_next;
        shift_out_reg <= shift_out_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.mant  = mant_reg;
    assign rsp.shift = shift_out_reg;

    `SGN_ASSERT_CLK(a_norm_pos_fits, (done_reg && !neg_reg) |-> (mant_reg[MANT_W-1] == 1'b0), "positive slope came out negative")

endmodule

@@ hw/rtl/segment_gradient_normalizer.sv @@
// Segment gradient normalizer: takes one tone-curve segment (gain and
// position at both ends) on the s_ stream and returns its slope as a signed
// mantissa plus a left-shift count on the m_ stream. The slope is
// dy/dx with 16 fraction bits, floored, then scaled by the largest shift
// 0..COEF_BITS that keeps it at or below 2^COEF_BITS-1; negative slopes
// always take shift COEF_BITS, and a zero-length segment returns status 1
// with zero mantissa and shift. One segment is in work at a time. A segment
// goes through the prep state, the bit-serial divider (one quotient bit a
// cycle), alignment and shift search in the normalizer, and the handoff
// steps (normalizer done, output load, idle). The result becomes valid in
// the same cycle as the block becomes ready for the next segment. A
// zero-length segment skips the divider and the normalizer. Output stalls
// hold a finished segment in the output state. The divider's bit-serial
// loop is the longest step. A finished result sits in the output register
// while the next segment is accepted.
module segment_gradient_normalizer #(
    parameter int COEF_BITS = 13,
    parameter int POS_BITS  = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // {pad, pos_end, pos_start, gain_end, gain_start} from bit 0 up:
    // gain_start, gain_end, pos_start, pos_end, zero pad
    input  logic [((2*sgn_pkg::GAIN_W+2*POS_BITS+7)/8)*8-1:0] s_tdata,
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // from bit 0 up: slope_mantissa, slope_shift, zero pad
    output logic [((sgn_pkg::MANT_W+sgn_pkg::SHIFT_W+7)/8)*8-1:0] m_tdata,
    // status: 0 ok, 1 zero-length segment
    output logic                  m_tuser
);

    localparam int GAIN_W  = sgn_pkg::GAIN_W;
    localparam int MANT_W  = sgn_pkg::MANT_W;
    localparam int SHIFT_W = sgn_pkg::SHIFT_W;
    localparam int M_DATA_W = ((MANT_W + SHIFT_W + 7) / 8) * 8;

    sgn_pkg::sgn_state_t state_reg, state_next;

    // captured segment
    logic [GAIN_W-1:0]   gain_start_reg, gain_start_next;
    logic [GAIN_W-1:0]   gain_end_reg, gain_end_next;
    logic [POS_BITS-1:0] pos_start_reg, pos_start_next;
    logic [POS_BITS-1:0] pos_end_reg, pos_end_next;
    logic                neg_reg, neg_next;
    logic                zero_reg, zero_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [MANT_W-1:0]   mant_out_reg, mant_out_next;
    logic [SHIFT_W-1:0]  shift_out_reg, shift_out_next;
    logic                status_out_reg, status_out_next;

    logic signed [GAIN_W:0]   dy;
    logic signed [POS_BITS:0] dx;
    logic [GAIN_W-1:0]        dy_mag;
    logic [POS_BITS-1:0]      dx_mag;

    logic                     in_accept;
    logic                     out_load;
    logic                     div_start;
    logic                     div_done;
    logic [sgn_pkg::QUOT_W-1:0] quot;
    sgn_pkg::norm_req_t       norm_req;
    sgn_pkg::norm_rsp_t       norm_rsp;

    assign in_accept = s_tvalid && s_tready;

    // signed differences and their magnitudes from the captured segment
    always_comb begin
        dy     = $signed({1'b0, gain_end_reg}) - $signed({1'b0, gain_start_reg});
        dx     = $signed({1'b0, pos_end_reg}) - $signed({1'b0, pos_start_reg});
        dy_mag = dy[GAIN_W] ? GAIN_W'(-dy) : dy[GAIN_W-1:0];
        dx_mag = dx[POS_BITS] ? POS_BITS'(-dx) : dx[POS_BITS-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sgn_pkg::ST_IDLE: if (in_accept) state_next = sgn_pkg::ST_PREP;
            sgn_pkg::ST_PREP: begin
                // skip the datapath for a zero-length segment
                state_next = (dx_mag == '0) ? sgn_pkg::ST_OUT : sgn_pkg::ST_DIV;
            end
            sgn_pkg::ST_DIV:  if (div_done) state_next = sgn_pkg::ST_NORM;
            sgn_pkg::ST_NORM: if (norm_rsp.done) state_next = sgn_pkg::ST_OUT;
            sgn_pkg::ST_OUT:  if (out_load) state_next = sgn_pkg::ST_IDLE;
            default:          state_next = sgn_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready       = (state_reg == sgn_pkg::ST_IDLE);
        div_start      = (state_reg == sgn_pkg::ST_PREP) && (dx_mag != '0);
        norm_req.start = (state_reg == sgn_pkg::ST_DIV) && div_done;
        norm_req.neg   = neg_reg;
        out_load       = (state_reg == sgn_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    // datapath registers
    always_comb begin
        gain_start_next = gain_start_reg;
        gain_end_next   = gain_end_reg;
        pos_start_next  = pos_start_reg;
        pos_end_next    = pos_end_reg;
        neg_next        = neg_reg;
        zero_next       = zero_reg;
        mant_out_next   = mant_out_reg;
        shift_out_next  = shift_out_reg;
        status_out_next = status_out_reg;

        if (in_accept) begin
            gain_start_next = s_tdata[GAIN_W-1:0];
            gain_end_next   = s_tdata[2*GAIN_W-1:GAIN_W];
            pos_start_next  = s_tdata[2*GAIN_W+POS_BITS-1:2*GAIN_W];
            pos_end_next    = s_tdata[2*GAIN_W+2*POS_BITS-1:2*GAIN_W+POS_BITS];
        end
        if (state_reg == sgn_pkg::ST_PREP) begin
            neg_next  = dy[GAIN_W] ^ dx[POS_BITS];
            zero_next = (dx_mag == '0);
        end
        if (out_load) begin
            if (zero_reg) begin
                mant_out_next   = '0;
                shift_out_next  = '0;
                status_out_next = 1'b1;
            end else begin
                mant_out_next   = norm_rsp.mant;
                shift_out_next  = norm_rsp.shift;
                status_out_next = 1'b0;
            end
        end
    end

    // hold the result until taken, drop valid on the handshake
    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sgn_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gain_start_reg <= gain_start_next;
        gain_end_reg   <= gain_end_next;
        pos_start_reg  <= pos_start_next;
        pos_end_reg    <= pos_end_next;
        neg_reg        <= neg_next;
        zero_reg       <= zero_next;
        mant_out_reg   <= mant_out_next;
        shift_out_reg  <= shift_out_next;
        status_out_reg <= status_out_next;
    end

    sgn_div #(
        .DEND_W (GAIN_W),
        .FRC_W  (sgn_pkg::FRAC_BITS),
        .DV_W   (POS_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dend    (dy_mag),
        .dvsr    (dx_mag),
        .done    (div_done),
        .quot    (quot)
    );

    sgn_norm #(
        .COEF_BITS (COEF_BITS)
    ) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (norm_req),
        .quot    (quot),
        .rsp     (norm_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({shift_out_reg, mant_out_reg});
    assign m_tuser  = status_out_reg;

    `SGN_ASSERT_CLK(a_valid_from_out, $rose(m_tvalid_reg) |-> $past(state_reg == sgn_pkg::ST_OUT), "result raised outside the output state")
    `SGN_ASSERT_CLK(a_div_done_in_div, div_done |-> (state_reg == sgn_pkg::ST_DIV), "divider finished while not awaited")
    `SGN_ASSERT_CLK(a_norm_done_in_norm, norm_rsp.done |-> (state_reg == sgn_pkg::ST_NORM), "normalizer finished while not awaited")

endmodule

@@ dv/segment_gradient_normalizer_tb.sv @@
module segment_gradient_normalizer_tb;

    localparam int COEF_BITS = 13;
    localparam int POS_BITS  = 14;
    localparam int FRC_W     = (COEF_BITS > 16) ? COEF_BITS : 16;
    localparam longint SLOPE_MAX = (longint'(1) << COEF_BITS) - 1;

    localparam int S_W = ((2*sgn_pkg::GAIN_W + 2*POS_BITS + 7) / 8) * 8;
    localparam int M_W = ((sgn_pkg::MANT_W + sgn_pkg::SHIFT_W + 7) / 8) * 8;

    localparam int NUM_DIR   = 20;
    localparam int NUM_RAND  = 1050;
    localparam int QUIET_TAIL = 150;     // last random words run with no idling
    localparam int DRAIN     = 60;       // wait after the last slope returns, watching for strays
    localparam int LIMIT     = 500000;   // cycle budget before the run is called hung

    // one result word, split into its fields
    typedef struct packed {
        logic [sgn_pkg::MANT_W-1:0]  mant;
        logic [sgn_pkg::SHIFT_W-1:0] shift;
        logic                        status;
    } slope_word_t;

    // one directed row: segment, plus a typed result where chk is set
    typedef struct packed {
        logic [12:0]                 gs;
        logic [12:0]                 ge;
        logic [13:0]                 ps;
        logic [13:0]                 pe;
        logic                        chk;
        logic [sgn_pkg::MANT_W-1:0]  mant;
        logic [sgn_pkg::SHIFT_W-1:0] shift;
        logic                        status;
    } seg_row_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic           m_tuser;

    slope_word_t slope_exp_q[$];   // slopes predicted for accepted segments, oldest first
    seg_row_t    dir_rows[NUM_DIR];

    bit idle_on = 1'b1;            // allow idle bursts on both sides
    int n_err      = 0;
    int n_checked  = 0;
    int n_sent     = 0;
    int n_zero_len = 0;
    int n_reversed = 0;
    int n_negative = 0;
    int cycle_count = 0;
    int stall_left  = 0;

    segment_gradient_normalizer #(
        .COEF_BITS (COEF_BITS),
        .POS_BITS  (POS_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Hung run: give up at the cycle budget.
    initial begin
        wait (cycle_count >= LIMIT);
        $display("timeout after %0d cycles, %0d slopes still pending", cycle_count,
                 slope_exp_q.size());
        $display("segment_gradient_normalizer_tb: errors");
        $finish;
    end

    // Compute the slope of one segment: truncating divide into an integer part
    // and a 16-bit fraction, then search shifts 0..COEF_BITS for the largest
    // scaled slope at or below the limit, stopping once the limit is reached.
    function automatic slope_word_t predict_slope(input logic [12:0] gs, input logic [12:0] ge,
                                                  input logic [13:0] ps, input logic [13:0] pe);
        longint dy, dx, q, r, f, t, mant;
        int best;
        bit found;
        slope_word_t w;
        dy = longint'(ge) - longint'(gs);
        dx = longint'(pe) - longint'(ps);
        w = '0;
        if (dx == 0) begin
            // zero-length segment: flag it, zero mantissa and shift
            w.status = 1'b1;
            return w;
        end
        q = dy / dx;                               // truncates toward zero
        r = dy - q * dx;
        f = (r * (longint'(1) << FRC_W)) / dx;
        mant  = SLOPE_MAX;
        best  = 0;
        found = 1'b0;
        for (int s = 0; s <= COEF_BITS; s++) begin
            // arithmetic shift floors negative fractions
            t = q * (longint'(1) << s) + (f >>> (FRC_W - s));
            if (t <= SLOPE_MAX) begin
                mant  = t;
                best  = s;
                found = 1'b1;
            end
            if (t >= SLOPE_MAX) break;
        end
        if (!found) begin
            // no shift fits: saturate at the limit with shift 0
            mant = SLOPE_MAX;
            best = 0;
        end
        w.mant  = mant[sgn_pkg::MANT_W-1:0];
        w.shift = best[sgn_pkg::SHIFT_W-1:0];
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        n_err++;
        $display("mismatch @%0d: %s", cycle_count, what);
    endtask

    // Drive one segment word and hold it until the block takes it, then
    // queue its slope. An optional idle burst comes first.
    task automatic send_segment(input seg_row_t row);
        int gap;
        slope_word_t w;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, row.pe, row.ps, row.ge, row.gs};
        do @(posedge aclk); while (!s_tready);
        if (row.chk) begin
            w.mant   = row.mant;
            w.shift  = row.shift;
            w.status = row.status;
        end else begin
            w = predict_slope(row.gs, row.ge, row.ps, row.pe);
        end
        slope_exp_q.push_back(w);
        n_sent++;
        if (row.pe == row.ps) n_zero_len++;
        if (row.pe < row.ps) n_reversed++;
        if (!w.status && w.mant[sgn_pkg::MANT_W-1]) n_negative++;
    endtask

    // Sink side: stall m_tready in random bursts while idling is allowed.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every result word against the oldest predicted slope.
    always @(posedge aclk) begin : check_results
        slope_word_t want;
        logic [sgn_pkg::MANT_W-1:0]  got_mant;
        logic [sgn_pkg::SHIFT_W-1:0] got_shift;
        if (aresetn && m_tvalid && m_tready) begin
            got_mant  = m_tdata[sgn_pkg::MANT_W-1:0];
            got_shift = m_tdata[sgn_pkg::MANT_W +: sgn_pkg::SHIFT_W];
            if (slope_exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word mant=%0h shift=%0d status=%0b",
                                          got_mant, got_shift, m_tuser));
            end else begin
                want = slope_exp_q.pop_front();
                n_checked++;
                if (got_mant !== want.mant)
                    report_mismatch($sformatf("word %0d slope_mantissa %0h, want %0h",
                                              n_checked, got_mant, want.mant));
                if (got_shift !== want.shift)
                    report_mismatch($sformatf("word %0d slope_shift %0d, want %0d",
                                              n_checked, got_shift, want.shift));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("word %0d status %0b, want %0b",
                                              n_checked, m_tuser, want.status));
            end
        end
    end

    initial begin : stimulus
        seg_row_t row;
        int kind, d, lo, hi;
        // Directed segments. A row with chk set carries its result; the
        // rest go through the predictor.
        //          gs        ge        ps         pe        chk   mant         shift status
        dir_rows = '{
            // zero-length segments
            '{13'd0,    13'd0,    14'd0,     14'd0,     1'b1, 27'd0,       4'd0,  1'b1},
            '{13'd8191, 13'd8191, 14'd16383, 14'd16383, 1'b1, 27'd0,       4'd0,  1'b1},
            '{13'd1234, 13'd4321, 14'd500,   14'd500,   1'b1, 27'd0,       4'd0,  1'b1},
            // steepest rise: slope hits the limit at shift 0
            '{13'd0,    13'd8191, 14'd0,     14'd1,     1'b1, 27'd8191,    4'd0,  1'b0},
            // steepest fall: -8191 * 2^13, negative slopes take shift COEF_BITS
            '{13'd8191, 13'd0,    14'd0,     14'd1,     1'b1, 27'h4002000, 4'd13, 1'b0},
            // flat segments never reach the limit
            '{13'd0,    13'd0,    14'd0,     14'd1,     1'b1, 27'd0,       4'd13, 1'b0},
            '{13'd5,    13'd5,    14'd100,   14'd9000,  1'b1, 27'd0,       4'd13, 1'b0},
            '{13'd8191, 13'd8191, 14'd0,     14'd16383, 1'b1, 27'd0,       4'd13, 1'b0},
            // reversed segments, signs carried through the divide
            '{13'd0,    13'd8191, 14'd16383, 14'd0,     1'b0, 27'd0,       4'd0,  1'b0},
            '{13'd8191, 13'd0,    14'd16383, 14'd0,     1'b0, 27'd0,       4'd0,  1'b0},
            '{13'd0,    13'd8191, 14'd1,     14'd0,     1'b0, 27'd0,       4'd0,  1'b0},
            '{13'd100,  13'd50,   14'd16383, 14'd16382, 1'b0, 27'd0,       4'd0,  1'b0},
            '{13'd8191, 13'd0,    14'd16383, 14'd16382, 1'b0, 27'd0,       4'd0,  1'b0},
            // longest span, tiny slopes either way
            '{13'd0,    13'd8191, 14'd0,     14'd16383, 1'b0, 27'd0,       4'd0,  1'b0},
            '{13'd0,    13'd1,    14'd0,     14'd16383, 1'b0, 27'd0,       4'd0,  1'b0},
            '{13'd1,    13'd0,    14'd0,     14'd16383, 1'b0, 27'd0,       4'd0,  1'b0},
            // search ends just below or right at the limit
            '{13'd0,    13'd1,    14'd0,     14'd1,     1'b0, 27'd0,       4'd0,  1'b0},
            '{13'd0,    13'd8190, 14'd0,     14'd1,     1'b0, 27'd0,       4'd0,  1'b0},
            '{13'd0,    13'd8191, 14'd0,     14'd2,     1'b0, 27'd0,       4'd0,  1'b0},
            // small negative slope with a floored fraction
            '{13'd3,    13'd0,    14'd0,     14'd7,     1'b0, 27'd0,       4'd0,  1'b0}
        };

        // Hold reset, then release it for good.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_segment(dir_rows[i]);

        for (int i = 0; i < NUM_RAND; i++) begin
            // quiet stretches every fourth hundred, and none at all at the tail
            idle_on = (i < NUM_RAND - QUIET_TAIL) && ((i / 100) % 4 != 3);
            row = '0;
            row.gs = 13'($urandom_range(0, 8191));
            row.ge = 13'($urandom_range(0, 8191));
            row.ps = 14'($urandom_range(0, 16383));
            row.pe = 14'($urandom_range(0, 16383));
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // zero-length segment
                row.pe = row.ps;
            end else if (kind <= 2) begin
                // short span: steep slopes, large integer parts
                d  = $urandom_range(1, 16);
                lo = int'(row.ps) - d;
                hi = int'(row.ps) + d;
                if (hi > 16383 || (lo >= 0 && $urandom_range(0, 1) == 0))
                    row.pe = 14'(lo);
                else
                    row.pe = 14'(hi);
            end else if (kind == 3) begin
                // gains at the rails
                row.gs = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
                row.ge = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
            end
            send_segment(row);
        end
        s_tvalid <= 1'b0;

        // Wait for every slope to come back, then watch for strays.
        while (slope_exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("sent %0d segments (%0d directed, %0d random): %0d zero-length, %0d reversed",
                 n_sent, NUM_DIR, NUM_RAND, n_zero_len, n_reversed);
        $display("checked %0d result words, %0d negative slopes, %0d mismatches",
                 n_checked, n_negative, n_err);
        if (n_err == 0) begin
            $display("segment_gradient_normalizer_tb: clean");
        end else begin
            $display("segment_gradient_normalizer_tb: errors");
        end
        $finish;
    end

endmodule
